// ----- rtl/dwo_pkg.sv -----
// Shared types and constants for the wheel odometry block.
package dwo_pkg;

    localparam int FULL_TURN = 23040;
    localparam logic signed [31:0] CORDIC_K_Q30 = 32'sd652032874;
    localparam int FRAC_BITS = 8;
    localparam int MAX_STEPS = 24;
    localparam int ANG_W = 26;
    localparam int VEC_W = 64;

    typedef enum logic [1:0] {
        CFG_USE_GYRO = 2'd0,
        CFG_HEADING_ORIGIN = 2'd1,
        CFG_HEADING_GAIN = 2'd2,
        CFG_NONE = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_WRAP,
        ST_PREP,
        ST_ROT,
        ST_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic do_head;
        logic do_wrap;
        logic do_prep;
        logic do_step;
        logic do_done;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic last_step;
    } status_t;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] i);
        logic [ANG_W-1:0] r;
        begin
            unique case (i)
                5'd0: r = 26'd2949120;
                5'd1: r = 26'd1740967;
                5'd2: r = 26'd919879;
                5'd3: r = 26'd466945;
                5'd4: r = 26'd234379;
                5'd5: r = 26'd117304;
                5'd6: r = 26'd58666;
                5'd7: r = 26'd29335;
                5'd8: r = 26'd14668;
                5'd9: r = 26'd7334;
                5'd10: r = 26'd3667;
                5'd11: r = 26'd1833;
                5'd12: r = 26'd917;
                5'd13: r = 26'd458;
                5'd14: r = 26'd229;
                5'd15: r = 26'd115;
                5'd16: r = 26'd57;
                5'd17: r = 26'd29;
                5'd18: r = 26'd14;
                5'd19: r = 26'd7;
                5'd20: r = 26'd4;
                5'd21: r = 26'd2;
                5'd22: r = 26'd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/dwo_ctrl.sv -----
// Sequencing controller for the wheel odometry block.
module dwo_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  dwo_pkg::status_t status,
    output dwo_pkg::cmd_t    cmd
);
    import dwo_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                cmd.do_head = 1'b1;
                state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                cmd.do_wrap = 1'b1;
                state_next = status.is_load ? ST_DONE : ST_PREP;
            end
            ST_PREP:
            begin
                cmd.do_prep = 1'b1;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                cmd.do_step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.do_done = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/dwo_datapath.sv -----
// Heading, travel and CORDIC datapath for the wheel odometry block.
module dwo_datapath #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  dwo_pkg::cmd_t       cmd,
    output dwo_pkg::status_t    status,
    input  logic                operation,
    input  logic signed [31:0]  left_travel,
    input  logic signed [31:0]  right_travel,
    input  logic [14:0]         gyro_heading,
    input  logic signed [31:0]  load_x,
    input  logic signed [31:0]  load_y,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic [14:0]         heading_out
);
    import dwo_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    logic               use_gyro_reg;
    logic [14:0]        origin_reg;
    logic [23:0]        gain_reg;
    logic signed [31:0] px_reg, py_reg, last_fwd_reg;
    logic               op_reg;
    logic signed [31:0] left_reg, right_reg, lx_reg, ly_reg;
    logic [14:0]        gyro_reg;
    logic signed [57:0] raw_reg;
    logic [14:0]        head_reg;
    logic signed [ANG_W-1:0] ang_reg;
    logic signed [VEC_W-1:0] x_reg, y_reg;
    logic [4:0]         step_reg;

    logic signed [32:0] diff;
    logic signed [57:0] prod;
    logic signed [32:0] sum;
    logic signed [31:0] fwd;
    logic signed [33:0] delta;
    logic signed [VEC_W-1:0] yscaled;
    logic signed [VEC_W-1:0] xs, ys;
    logic signed [ANG_W-1:0] atan_s;
    logic signed [41:0] raw_div;
    logic [35:0]        turn_ext;
    logic [13:0]        fold_sum;
    logic [28:0]        fold_prod;
    logic [13:0]        fold_rem;
    logic [14:0]        raw_wrap;
    logic [15:0]        hsum;
    logic [14:0]        hwrap;
    logic signed [ANG_W-1:0] a0, a1;
    logic               flip;
    logic signed [VEC_W-1:0] dx_full, dy_full;
    logic signed [33:0] nx, ny;
    logic signed [VEC_W-1:0] yprod;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > 34'sd2147483647)
            begin
                return 32'sh7FFFFFFF;
            end
            else if (v < -34'sd2147483648)
            begin
                return 32'sh80000000;
            end
            return v[31:0];
        end
    endfunction

    assign diff = 33'(right_reg) - 33'(left_reg);
    assign prod = 58'(diff) * $signed({34'd0, gain_reg});
    assign sum = 33'(left_reg) + 33'(right_reg);
    assign fwd = sum[32:1];
    assign delta = 34'(fwd) - 34'(last_fwd_reg);
    assign yprod = 64'(delta) * 64'(CORDIC_K_Q30);
    assign yscaled = yprod >>> (30 - FRAC_BITS);
    assign raw_div = 42'(raw_reg >>> 16);

    // full turn is 512 * 45: keep the low 9 bits, reduce the rest mod 45
    // 2^12 folds to 1 mod 45, and the sign weight 2^36 folds to 1, so add 44 when negative
    assign turn_ext = {{3{raw_div[41]}}, raw_div[41:9]};
    assign fold_sum = 14'(turn_ext[11:0]) + 14'(turn_ext[23:12]) + 14'(turn_ext[35:24])
                      + (turn_ext[35] ? 14'd44 : 14'd0);
    assign fold_prod = 29'(fold_sum) * 29'd23302;
    assign fold_rem = fold_sum - 14'(fold_prod[28:20]) * 14'd45;
    assign raw_wrap = {fold_rem[5:0], raw_div[8:0]};

    assign hsum = {1'b0, raw_wrap} + {1'b0, (origin_reg >= 15'd23040)
                  ? origin_reg - 15'd23040 : origin_reg};
    assign hwrap = (hsum >= 16'd23040) ? 15'(hsum - 16'd23040) : hsum[14:0];

    always_comb
    begin
        a0 = ANG_W'({11'd0, head_reg}) <<< 10;
        if (a0 > ANG_W'(23040 * 512))
        begin
            a0 = a0 - ANG_W'(23040 * 1024);
        end
        flip = 1'b0;
        a1 = a0;
        if (a0 > ANG_W'(23040 * 256))
        begin
            a1 = a0 - ANG_W'(23040 * 512);
            flip = 1'b1;
        end
        else if (a0 < -ANG_W'(23040 * 256))
        begin
            a1 = a0 + ANG_W'(23040 * 512);
            flip = 1'b1;
        end
    end

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign atan_s = $signed(atan_entry(step_reg));
    assign dx_full = (x_reg + VEC_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign dy_full = (y_reg + VEC_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign nx = 34'(px_reg) + 34'(dx_full);
    assign ny = 34'(py_reg) + 34'(dy_full);

    assign status.is_load = op_reg;
    assign status.last_step = (step_reg == 5'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_gyro_reg <= 1'b0;
            origin_reg <= '0;
            gain_reg <= 24'd65536;
            px_reg <= '0;
            py_reg <= '0;
            last_fwd_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_USE_GYRO: use_gyro_reg <= cfg_data[0];
                    CFG_HEADING_ORIGIN:
                    begin
                        origin_reg <= cfg_data[14:0];
                        last_fwd_reg <= '0;
                    end
                    CFG_HEADING_GAIN: gain_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.do_wrap && op_reg)
            begin
                px_reg <= lx_reg;
                py_reg <= ly_reg;
            end
            if (cmd.do_prep)
            begin
                last_fwd_reg <= fwd;
            end
            if (cmd.do_done && !op_reg)
            begin
                px_reg <= sat32(nx);
                py_reg <= sat32(ny);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= operation;
            left_reg <= left_travel;
            right_reg <= right_travel;
            gyro_reg <= gyro_heading;
            lx_reg <= load_x;
            ly_reg <= load_y;
        end
        if (cmd.do_head)
        begin
            raw_reg <= use_gyro_reg ? (58'sd23040 - 58'($signed({1'b0, gyro_reg})))
                                    <<< 16 : prod;
        end
        if (cmd.do_wrap)
        begin
            head_reg <= hwrap;
        end
        if (cmd.do_prep)
        begin
            x_reg <= '0;
            y_reg <= flip ? -yscaled : yscaled;
            ang_reg <= a1;
            step_reg <= '0;
        end
        if (cmd.do_step)
        begin
            if (!ang_reg[ANG_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                ang_reg <= ang_reg - atan_s;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                ang_reg <= ang_reg + atan_s;
            end
            step_reg <= step_reg + 5'd1;
        end
    end

    assign pos_x = px_reg;
    assign pos_y = py_reg;
    assign heading_out = head_reg;

endmodule

// ----- rtl/differential_wheel_odometry.sv -----
// Throughput: one item at a time; the iterative CORDIC does one micro-rotation per cycle,
// and a new item is accepted only after the previous result has been handed off.
// Reset: rst_n clears position, last travel and config registers (gain to 65536) asynchronously.
// Top level of the differential-drive wheel odometry block.
module differential_wheel_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [31:0] left_travel,
    input  logic signed [31:0] right_travel,
    input  logic [14:0]        gyro_heading,
    input  logic signed [31:0] load_x,
    input  logic signed [31:0] load_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [14:0]        heading_out
);
    import dwo_pkg::*;

    cmd_t    cmd;
    status_t status;

    dwo_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
    );

    dwo_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .status(status), .operation(operation),
        .left_travel(left_travel), .right_travel(right_travel),
        .gyro_heading(gyro_heading), .load_x(load_x), .load_y(load_y),
        .pos_x(pos_x), .pos_y(pos_y), .heading_out(heading_out)
    );

endmodule

// ----- rtl/dwo_checker.sv -----
// Port-level checker for the wheel odometry block, with its bind.
module dwo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] heading_out
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken while result pending");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading_out < 15'd23040) else $error("heading out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready && !out_valid)
        else $error("no work cycle after accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(heading_out))
        else $error("result dropped");
endmodule

bind differential_wheel_odometry dwo_checker u_dwo_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .heading_out(heading_out)
);

// ----- verif/odometry_checker.sv -----
`timescale 1ns / 1ps
// Checker for the wheel odometry block: tracks config, predicts each result and compares.
module odometry_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               operation,
    input  logic signed [31:0] left_travel,
    input  logic signed [31:0] right_travel,
    input  logic [14:0]        gyro_heading,
    input  logic signed [31:0] load_x,
    input  logic signed [31:0] load_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic [14:0]        heading_out,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count
);
    import dwo_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [14:0]        heading;
    } pose_t;

    pose_t pose_queue[$];

    logic               gyro_mode;
    logic [14:0]        origin;
    logic [23:0]        gain;
    logic signed [31:0] odo_x;
    logic signed [31:0] odo_y;
    logic signed [31:0] prev_fwd;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint wrap_angle(longint v);
        longint r;
        r = v % FULL_TURN;
        if (r < 0)
            r += FULL_TURN;
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint atan_val(int i);
        longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
        return t[i];
    endfunction

    task automatic rotate_travel(input longint d, input longint h,
                                 output longint dx, output longint dy);
        longint a;
        longint half;
        longint quarter;
        longint x;
        longint y;
        longint xs;
        longint ys;
        a = h * 1024;
        half = longint'(FULL_TURN) * 512;
        quarter = longint'(FULL_TURN) * 256;
        x = 0;
        y = floor_shift(d * longint'(CORDIC_K_Q30), 30 - FRAC_BITS);
        if (a > half)
            a -= 2 * half;
        if (a > quarter)
        begin
            a -= half;
            y = -y;
        end
        else if (a < -quarter)
        begin
            a += half;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < MAX_STEPS; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (a >= 0)
            begin
                x = x - ys;
                y = y + xs;
                a -= atan_val(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                a += atan_val(i);
            end
        end
        dx = floor_shift(x + (1 << (FRAC_BITS - 1)), FRAC_BITS);
        dy = floor_shift(y + (1 << (FRAC_BITS - 1)), FRAC_BITS);
    endtask

    task automatic predict_pose();
        longint l;
        longint r;
        longint raw;
        longint hdg;
        longint s;
        longint fwd;
        longint dx;
        longint dy;
        pose_t p;
        l = left_travel;
        r = right_travel;
        if (gyro_mode)
            raw = FULL_TURN - longint'(gyro_heading);
        else
            raw = floor_shift((r - l) * longint'(gain), 16);
        hdg = wrap_angle(wrap_angle(raw) + longint'(origin));
        if (operation)
        begin
            odo_x = load_x;
            odo_y = load_y;
        end
        else
        begin
            s = l + r;
            fwd = s >>> 1;
            rotate_travel(fwd - longint'(prev_fwd), hdg, dx, dy);
            odo_x = clamp32(longint'(odo_x) + dx);
            odo_y = clamp32(longint'(odo_y) + dy);
            prev_fwd = fwd[31:0];
        end
        p.x = odo_x;
        p.y = odo_y;
        p.heading = hdg[14:0];
        pose_queue.push_back(p);
    endtask

    assign pending_count = pose_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        pose_t e;
        if (!rst_n)
        begin
            gyro_mode <= 1'b0;
            origin <= '0;
            gain <= 24'd65536;
            odo_x = 0;
            odo_y = 0;
            prev_fwd = 0;
            fail_count <= 0;
            result_count <= 0;
            pose_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_USE_GYRO: gyro_mode <= cfg_data[0];
                    CFG_HEADING_ORIGIN:
                    begin
                        origin <= cfg_data[14:0];
                        prev_fwd = 0;
                    end
                    CFG_HEADING_GAIN: gain <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (pose_queue.size() == 0)
                begin
                    $error("unexpected result transaction");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = pose_queue.pop_front();
                    if (pos_x !== e.x || pos_y !== e.y || heading_out !== e.heading)
                    begin
                        if (pos_x !== e.x)
                            $error("pos_x expected %0d actual %0d", e.x, pos_x);
                        if (pos_y !== e.y)
                            $error("pos_y expected %0d actual %0d", e.y, pos_y);
                        if (heading_out !== e.heading)
                            $error("heading_out expected %0d actual %0d",
                                   e.heading, heading_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_pose();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the wheel odometry block: stimulus, config phases and verdict.
module tb_top;
    import dwo_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               operation;
    logic signed [31:0] left_travel;
    logic signed [31:0] right_travel;
    logic [14:0]        gyro_heading;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [14:0]        heading_out;
    int                 fail_count;
    int                 pending_count;
    int                 result_count;
    int                 idle_cycles;
    int                 sent_count;
    int                 ready_gap;
    logic               long_hold;
    logic signed [31:0] wheel_base;

    differential_wheel_odometry u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .left_travel(left_travel), .right_travel(right_travel),
        .gyro_heading(gyro_heading), .load_x(load_x), .load_y(load_y),
        .out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x), .pos_y(pos_y),
        .heading_out(heading_out)
    );

    odometry_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .left_travel(left_travel), .right_travel(right_travel),
        .gyro_heading(gyro_heading), .load_x(load_x), .load_y(load_y),
        .out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x), .pos_y(pos_y),
        .heading_out(heading_out), .fail_count(fail_count),
        .pending_count(pending_count), .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(input logic op, input logic signed [31:0] l,
                             input logic signed [31:0] r, input logic [14:0] g,
                             input logic signed [31:0] lx, input logic signed [31:0] ly);
        operation <= op;
        left_travel <= l;
        right_travel <= r;
        gyro_heading <= g;
        load_x <= lx;
        load_y <= ly;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_gapped(input logic op, input logic signed [31:0] l,
                               input logic signed [31:0] r, input logic [14:0] g,
                               input logic signed [31:0] lx, input logic signed [31:0] ly,
                               input logic use_gaps);
        int gap;
        gap = use_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        send_item(op, l, r, g, lx, ly);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand32();
        return $urandom();
    endfunction

    task automatic random_phase(input int count, input logic gaps);
        logic signed [31:0] step;
        logic [14:0] g;
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            g = (kind < 5) ? 15'($urandom_range(23040, 32767)) : 15'($urandom_range(0, 23039));
            if (kind < 8)
                send_gapped(1'b1, rand32(), rand32(), g, rand32(), rand32(), gaps);
            else if (kind < 18)
                send_gapped(1'b0, rand32(), rand32(), g, rand32(), rand32(), gaps);
            else
            begin
                step = $urandom_range(0, 1) ? $signed(32'($urandom_range(0, 4096)))
                                            : -$signed(32'($urandom_range(0, 4096)));
                wheel_base = wheel_base + step;
                send_gapped(1'b0, wheel_base, wheel_base + $signed(32'($urandom_range(0, 2000)))
                            - 1000, g, rand32(), rand32(), gaps);
            end
        end
    endtask

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_gap <= 0;
        end
        else if (long_hold)
            out_ready <= 1'b0;
        else if (ready_gap > 0)
        begin
            out_ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            out_ready <= 1'b0;
            ready_gap <= $urandom_range(10, 60);
        end
        else
            out_ready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_USE_GYRO;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = 1'b0;
        left_travel = '0;
        right_travel = '0;
        gyro_heading = '0;
        load_x = '0;
        load_y = '0;
        long_hold = 1'b0;
        idle_cycles = 0;
        sent_count = 0;
        wheel_base = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(1'b0, 32'sd1000, 32'sd1000, 15'd0, 0, 0);
        send_item(1'b0, 32'sd3000, 32'sd1000, 15'd0, 0, 0);
        send_item(1'b0, -32'sd3001, -32'sd4000, 15'd0, 0, 0);
        send_item(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 15'd0, 0, 0);
        send_item(1'b0, 32'sh80000000, 32'sh7FFFFFFF, 15'd0, 0, 0);
        send_item(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 15'd0, 0, 0);
        send_item(1'b1, 0, 0, 15'h7FFF, 32'sh7FFFFFF0, 32'sh80000010);
        send_item(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 15'd0, 0, 0);
        send_item(1'b0, 32'sh80000000, 32'sh80000000, 15'd0, 0, 0);
        send_item(1'b1, 0, 0, 15'd0, 32'sh7FFFFFFF, 32'sh80000000);
        send_item(1'b1, 0, 0, 15'd0, 32'sh80000000, 32'sh7FFFFFFF);
        send_item(1'b1, 0, 0, 15'd0, 0, 0);
        drain();

        write_reg(CFG_USE_GYRO, 24'd1);
        write_reg(CFG_HEADING_ORIGIN, 24'd23039);
        send_item(1'b0, 32'sd5000, 32'sd5000, 15'd0, 0, 0);
        send_item(1'b0, 32'sd9000, 32'sd9000, 15'd5760, 0, 0);
        send_item(1'b0, 32'sd1000, 32'sd1000, 15'd11520, 0, 0);
        send_item(1'b0, 32'sd7000, 32'sd7000, 15'd17280, 0, 0);
        send_item(1'b0, 32'sd2000, 32'sd2000, 15'd23039, 0, 0);
        send_item(1'b0, 32'sd8000, 32'sd8000, 15'h7FFF, 0, 0);
        send_item(1'b1, 0, 0, 15'd30000, 32'sd5, -32'sd5);
        drain();

        write_reg(CFG_USE_GYRO, 24'd0);
        write_reg(CFG_HEADING_ORIGIN, 24'h7FFF);
        write_reg(CFG_HEADING_GAIN, 24'hFFFFFF);
        write_reg(CFG_NONE, 24'hFFFFFF);
        send_item(1'b0, 32'sh80000000, 32'sh7FFFFFFF, 15'd0, 0, 0);
        send_item(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 15'd0, 0, 0);
        drain();

        write_reg(CFG_HEADING_GAIN, 24'd0);
        write_reg(CFG_HEADING_ORIGIN, 24'd0);
        wheel_base = 0;
        random_phase(300, 1'b1);
        drain();

        write_reg(CFG_HEADING_GAIN, 24'd65536);
        wheel_base = 0;
        random_phase(300, 1'b1);

        fork
            begin
                long_hold = 1'b1;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            random_phase(40, 1'b0);
        join
        drain();

        write_reg(CFG_USE_GYRO, 24'd1);
        write_reg(CFG_HEADING_ORIGIN, 24'($urandom_range(0, 23039)));
        wheel_base = 0;
        random_phase(300, 1'b1);
        drain();

        write_reg(CFG_USE_GYRO, 24'd0);
        write_reg(CFG_HEADING_GAIN, 24'($urandom_range(0, 24'hFFFFFF)));
        write_reg(CFG_HEADING_ORIGIN, 24'($urandom_range(0, 32767)));
        wheel_base = 0;
        random_phase(300, 1'b0);
        drain();

        write_reg(CFG_HEADING_GAIN, 24'd1024);
        write_reg(CFG_HEADING_ORIGIN, 24'd11520);
        wheel_base = 0;
        random_phase(380, 1'b1);
        drain();

        $display("Sent %0d items over eight register settings, %0d results checked.",
                 sent_count, result_count);
        $display("Covered gyro and wheel headings, loads, saturation and output stalls.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- differential_wheel_odometry.f -----
rtl/dwo_pkg.sv
rtl/dwo_ctrl.sv
rtl/dwo_datapath.sv
rtl/differential_wheel_odometry.sv
rtl/dwo_checker.sv
verif/odometry_checker.sv
verif/tb_top.sv
